[rtl/witt_pkg.sv]
package witt_pkg;

    // Tile geometry: four rows of four samples.
    localparam int unsigned NUM_COLS  = 4;
    localparam int unsigned ROW_IDX_W = 2;

    typedef logic [ROW_IDX_W-1:0] row_idx_t;

    localparam row_idx_t FIRST_ROW = 2'd0;
    localparam row_idx_t LAST_ROW  = 2'd3;

    // Status of the transformed-row bank, seen by the output stage.
    typedef struct packed {
        logic     valid;
        row_idx_t row;
        logic     last;
    } bank_stat_t;

endpackage

[rtl/witt_row_combine.sv]
module witt_row_combine #(
    parameter int unsigned SAMPLE_WIDTH = 16
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            in_valid,
    output logic                                            in_ready,
    input  logic [witt_pkg::NUM_COLS-1:0][SAMPLE_WIDTH-1:0] samples,
    input  logic                                            bank_free,
    output logic                                            load,
    output logic [witt_pkg::NUM_COLS-1:0][witt_pkg::NUM_COLS-1:0][SAMPLE_WIDTH:0] m_rows
);

    localparam int unsigned MW = SAMPLE_WIDTH + 1;

    logic [SAMPLE_WIDTH-1:0] row_store_reg [0:2][witt_pkg::NUM_COLS];
    witt_pkg::row_idx_t      row_count_reg;
    witt_pkg::row_idx_t      row_count_next;
    logic                    accept;
    logic                    fourth_row;

    assign fourth_row = (row_count_reg == witt_pkg::LAST_ROW);
    // Rows 0..2 only go to the store; row 3 needs room in the bank.
    assign in_ready   = !fourth_row || bank_free;
    assign accept     = in_valid && in_ready;
    assign load       = accept && fourth_row;

    always_comb
    begin
        row_count_next = row_count_reg;
        if (accept)
        begin
            row_count_next = row_count_reg + witt_pkg::row_idx_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= witt_pkg::FIRST_ROW;
        end
        else
        begin
            row_count_reg <= row_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !fourth_row)
        begin
            for (int j = 0; j < witt_pkg::NUM_COLS; j++)
            begin
                row_store_reg[row_count_reg][j] <= samples[j];
            end
        end
    end

    // Row combine: r0-r2, r1+r2, r2-r1, r3-r1, one bit of growth.
    for (genvar j = 0; j < witt_pkg::NUM_COLS; j++)
    begin : g_col
        logic signed [MW-1:0] r0;
        logic signed [MW-1:0] r1;
        logic signed [MW-1:0] r2;
        logic signed [MW-1:0] r3;

        assign r0 = {row_store_reg[0][j][SAMPLE_WIDTH-1], row_store_reg[0][j]};
        assign r1 = {row_store_reg[1][j][SAMPLE_WIDTH-1], row_store_reg[1][j]};
        assign r2 = {row_store_reg[2][j][SAMPLE_WIDTH-1], row_store_reg[2][j]};
        assign r3 = {samples[j][SAMPLE_WIDTH-1], samples[j]};

        assign m_rows[0][j] = r0 - r2;
        assign m_rows[1][j] = r1 + r2;
        assign m_rows[2][j] = r2 - r1;
        assign m_rows[3][j] = r3 - r1;
    end

endmodule

[rtl/witt_tile_bank.sv]
module witt_tile_bank #(
    parameter int unsigned SAMPLE_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic [witt_pkg::NUM_COLS-1:0][witt_pkg::NUM_COLS-1:0][SAMPLE_WIDTH:0] m_rows,
    input  logic                 pop,
    output witt_pkg::bank_stat_t stat,
    output logic                 bank_free,
    output logic [witt_pkg::NUM_COLS-1:0][SAMPLE_WIDTH:0] row_data
);

    logic [witt_pkg::NUM_COLS-1:0][witt_pkg::NUM_COLS-1:0][SAMPLE_WIDTH:0] bank_reg;
    logic                valid_reg;
    logic                valid_next;
    witt_pkg::row_idx_t  emit_idx_reg;
    witt_pkg::row_idx_t  emit_idx_next;
    logic                last_row;

    assign last_row   = (emit_idx_reg == witt_pkg::LAST_ROW);
    assign bank_free  = !valid_reg || (pop && last_row);
    assign stat.valid = valid_reg;
    assign stat.row   = emit_idx_reg;
    assign stat.last  = last_row;
    assign row_data   = bank_reg[emit_idx_reg];

    always_comb
    begin
        valid_next    = valid_reg;
        emit_idx_next = emit_idx_reg;
        if (load)
        begin
            valid_next    = 1'b1;
            emit_idx_next = witt_pkg::FIRST_ROW;
        end
        else if (pop)
        begin
            emit_idx_next = emit_idx_reg + witt_pkg::row_idx_t'(1);
            if (last_row)
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            emit_idx_reg <= witt_pkg::FIRST_ROW;
        end
        else
        begin
            valid_reg    <= valid_next;
            emit_idx_reg <= emit_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bank_reg <= m_rows;
        end
    end

endmodule

[rtl/witt_col_out.sv]
module witt_col_out #(
    parameter int unsigned SAMPLE_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  witt_pkg::bank_stat_t stat,
    input  logic [witt_pkg::NUM_COLS-1:0][SAMPLE_WIDTH:0] row_data,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [witt_pkg::NUM_COLS-1:0][SAMPLE_WIDTH+1:0] coef,
    output witt_pkg::row_idx_t   out_row,
    output logic                 tile_done
);

    localparam int unsigned CW = SAMPLE_WIDTH + 2;

    logic                                   valid_reg;
    logic                                   valid_next;
    logic [witt_pkg::NUM_COLS-1:0][CW-1:0]  coef_reg;
    logic [witt_pkg::NUM_COLS-1:0][CW-1:0]  coef_next;
    witt_pkg::row_idx_t                     row_reg;
    logic                                   done_reg;
    logic signed [CW-1:0]                   m0;
    logic signed [CW-1:0]                   m1;
    logic signed [CW-1:0]                   m2;
    logic signed [CW-1:0]                   m3;

    assign pop = stat.valid && (!valid_reg || out_ready);

    assign m0 = {row_data[0][SAMPLE_WIDTH], row_data[0]};
    assign m1 = {row_data[1][SAMPLE_WIDTH], row_data[1]};
    assign m2 = {row_data[2][SAMPLE_WIDTH], row_data[2]};
    assign m3 = {row_data[3][SAMPLE_WIDTH], row_data[3]};

    // Column combine within the row.
    assign coef_next[0] = m0 - m2;
    assign coef_next[1] = m1 + m2;
    assign coef_next[2] = m2 - m1;
    assign coef_next[3] = m3 - m1;

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            coef_reg <= coef_next;
            row_reg  <= stat.row;
            done_reg <= stat.last;
        end
    end

    assign out_valid = valid_reg;
    assign coef      = coef_reg;
    assign out_row   = row_reg;
    assign tile_done = done_reg;

endmodule

[rtl/winograd_input_tile_transform_core.sv]
// Order: a fourth tile row is loaded into the bank register, then the first transformed
//   row goes to the output register; the rest follow one per cycle while tready is high.
// Throughput: one row word in and one row word out per cycle while m_axis_tready is high,
//   set by the single-row output register and the one-tile transformed-row bank.
// Reset (rst_n, async, active low) clears the row counter and all valid flags; sample and
//   coefficient storage is not reset.
module winograd_input_tile_transform_core #(
    parameter int unsigned SAMPLE_WIDTH = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,

    // Input: one tile row per word.
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // tdata: sample_0, sample_1, sample_2, sample_3 (SAMPLE_WIDTH each), zero pad
    input  logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0]         s_axis_tdata,

    // Output: one transformed row per word.
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // tdata: coef_0, coef_1, coef_2, coef_3 (SAMPLE_WIDTH+2 each), zero pad
    output logic [((4*(SAMPLE_WIDTH+2)+7)/8)*8-1:0]     m_axis_tdata,
    // tuser: out_row
    output logic [1:0]                                  m_axis_tuser,
    // tlast: tile_done, set on transformed row 3
    output logic                                        m_axis_tlast
);

    localparam int unsigned MW    = SAMPLE_WIDTH + 1;
    localparam int unsigned CW    = SAMPLE_WIDTH + 2;
    localparam int unsigned OUT_W = ((4*CW+7)/8)*8;

    logic [witt_pkg::NUM_COLS-1:0][SAMPLE_WIDTH-1:0]                 samples;
    logic [witt_pkg::NUM_COLS-1:0][witt_pkg::NUM_COLS-1:0][MW-1:0]   m_rows;
    logic [witt_pkg::NUM_COLS-1:0][MW-1:0]                           row_data;
    logic [witt_pkg::NUM_COLS-1:0][CW-1:0]                           coef;
    logic                 load;
    logic                 bank_free;
    logic                 pop;
    witt_pkg::bank_stat_t bank_stat;

    for (genvar j = 0; j < witt_pkg::NUM_COLS; j++)
    begin : g_unpack
        assign samples[j] = s_axis_tdata[j*SAMPLE_WIDTH +: SAMPLE_WIDTH];
    end

    // Rows 0..2 are held; row 3 triggers the row combine into the bank.
    witt_row_combine #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_row_combine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .samples   (samples),
        .bank_free (bank_free),
        .load      (load),
        .m_rows    (m_rows)
    );

    // Holds one tile of row-combined values; drained one row per cycle while the output
    // stage pops, and refilled on the same edge its last row drains.
    witt_tile_bank #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_tile_bank (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .m_rows    (m_rows),
        .pop       (pop),
        .stat      (bank_stat),
        .bank_free (bank_free),
        .row_data  (row_data)
    );

    // Column combine and output register.
    witt_col_out #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_col_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (bank_stat),
        .row_data  (row_data),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .coef      (coef),
        .out_row   (m_axis_tuser),
        .tile_done (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_W'(coef);

    // tlast marks exactly the last transformed row.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == witt_pkg::LAST_ROW)))
        else $error("tlast does not match row index");

    // Rest of a tile follows without a bubble.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("gap inside a transformed tile");

    // A fourth-row accept fills the bank starting at row 0.
    assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (bank_stat.valid && (bank_stat.row == witt_pkg::FIRST_ROW)))
        else $error("bank not loaded after fourth row");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int SW    = 16;
    localparam int CW    = SW + 2;
    localparam int DIN_W = ((4 * SW + 7) / 8) * 8;
    localparam int DOUT_W = ((4 * CW + 7) / 8) * 8;

    // Tiles in the random part; 4 rows each, so roughly 500 row words.
    localparam int RANDOM_TILES = 125;
    // The last rows go through with both sides running flat out.
    localparam int CALM_ROWS = 48;

    typedef logic signed [SW-1:0] sample_t;
    typedef logic signed [CW-1:0] coef_t;

    // Tile patterns for the directed part.
    typedef enum int {
        PAT_ZERO,
        PAT_ALL_MAX,
        PAT_ALL_MIN,
        PAT_CHECKER,
        PAT_CHECKER_INV,
        PAT_COEF_PEAK,
        PAT_RANDOM
    } tile_pat_e;

    localparam sample_t S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam sample_t S_MIN = {1'b1, {(SW-1){1'b0}}};

    typedef struct packed {
        logic [DIN_W-1:0] word;
        logic             drain_first;   // hold off until every due row has come out
    } queued_row_t;

    typedef struct packed {
        coef_t [witt_pkg::NUM_COLS-1:0] coef;
        witt_pkg::row_idx_t             row;
        logic                           last;
    } xform_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DIN_W-1:0]  s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DOUT_W-1:0] m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tlast;

    winograd_input_tile_transform_core #(
        .SAMPLE_WIDTH (SW)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    always
    begin
        #4;
        clk = 1'b1;
        #4;
        clk = 1'b0;
    end

    queued_row_t tile_rows_queued[$];
    xform_row_t  transformed_rows_due[$];

    // Predictor state: first three rows of the current tile and how many have come in.
    sample_t            held_rows[3][witt_pkg::NUM_COLS];
    witt_pkg::row_idx_t rows_held = witt_pkg::FIRST_ROW;

    int errors = 0;
    int words_in = 0;
    int rows_checked = 0;
    int tiles_done = 0;
    int drains = 0;
    int send_gap = 0;
    int send_gap_pct = 0;
    int recv_stall = 0;
    int recv_stall_pct = 0;

    queued_row_t next_row;
    xform_row_t  due_row;
    coef_t       got_coef;

    function automatic bit calm_tail();
        return tile_rows_queued.size() < CALM_ROWS;
    endfunction

    // Idle density for the next stretch: none, light or heavy.
    function automatic int pick_pct();
        case ($urandom_range(2))
            0:       return 0;
            1:       return 20;
            default: return 50;
        endcase
    endfunction

    // Row combine then column combine, exact in int and cut to the coef width.
    function automatic void transform_tile_row(logic [DIN_W-1:0] word);
        int         cur[witt_pkg::NUM_COLS];
        int         m[4][witt_pkg::NUM_COLS];
        xform_row_t xr;
        begin
            for (int j = 0; j < witt_pkg::NUM_COLS; j++)
                cur[j] = int'($signed(word[j*SW +: SW]));
            if (rows_held != witt_pkg::LAST_ROW)
            begin
                for (int j = 0; j < witt_pkg::NUM_COLS; j++)
                    held_rows[rows_held][j] = sample_t'(cur[j]);
                rows_held = rows_held + 1'b1;
            end
            else
            begin
                for (int j = 0; j < witt_pkg::NUM_COLS; j++)
                begin
                    m[0][j] = int'(held_rows[0][j]) - int'(held_rows[2][j]);
                    m[1][j] = int'(held_rows[1][j]) + int'(held_rows[2][j]);
                    m[2][j] = int'(held_rows[2][j]) - int'(held_rows[1][j]);
                    m[3][j] = cur[j] - int'(held_rows[1][j]);
                end
                for (int i = 0; i < 4; i++)
                begin
                    xr.coef[0] = coef_t'(m[i][0] - m[i][2]);
                    xr.coef[1] = coef_t'(m[i][1] + m[i][2]);
                    xr.coef[2] = coef_t'(m[i][2] - m[i][1]);
                    xr.coef[3] = coef_t'(m[i][3] - m[i][1]);
                    xr.row     = witt_pkg::row_idx_t'(i);
                    xr.last    = (witt_pkg::row_idx_t'(i) == witt_pkg::LAST_ROW);
                    transformed_rows_due.push_back(xr);
                end
                rows_held = witt_pkg::FIRST_ROW;
                tiles_done++;
            end
        end
    endfunction

    function automatic sample_t tile_sample(tile_pat_e pat, int r, int c);
        case (pat)
            PAT_ZERO:        return '0;
            PAT_ALL_MAX:     return S_MAX;
            PAT_ALL_MIN:     return S_MIN;
            PAT_CHECKER:     return ((r + c) % 2) ? S_MAX : S_MIN;
            PAT_CHECKER_INV: return ((r + c) % 2) ? S_MIN : S_MAX;
            // drives coef_0/coef_3 of the first rows toward their limits
            PAT_COEF_PEAK:   return ((r == 0) ^ (c >= 2)) ? S_MAX : S_MIN;
            default:         return sample_t'($urandom);
        endcase
    endfunction

    task automatic queue_tile(tile_pat_e pat, bit drain, bit edgy);
        queued_row_t qr;
        sample_t     s;
        for (int r = 0; r < 4; r++)
        begin
            qr.word        = '0;
            qr.drain_first = drain && (r == 0);
            for (int c = 0; c < witt_pkg::NUM_COLS; c++)
            begin
                s = tile_sample(pat, r, c);
                // edgy tiles mix random samples with the extremes and zero
                if (edgy)
                    case ($urandom_range(3))
                        0: s = S_MAX;
                        1: s = S_MIN;
                        2: s = '0;
                        default: ;
                    endcase
                qr.word[c*SW +: SW] = s;
            end
            tile_rows_queued.push_back(qr);
        end
    endtask

    // Sender: one row word per free slot, with bursts of idle cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                transform_tile_row(s_tdata);
                words_in++;
                if (words_in % 64 == 0)
                    send_gap_pct = pick_pct();
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (tile_rows_queued.size() != 0 &&
                         !(tile_rows_queued[0].drain_first &&
                           transformed_rows_due.size() != 0))
                begin
                    next_row = tile_rows_queued.pop_front();
                    if (next_row.drain_first)
                        drains++;
                    s_tdata  <= next_row.word;
                    s_tvalid <= 1'b1;
                    if (!calm_tail() && $urandom_range(99) < send_gap_pct)
                        send_gap <= $urandom_range(7, 1);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall bursts on tready, and a field-by-field check of each word.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            recv_stall <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (transformed_rows_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected row: expected none, actual tdata=%h row=%0d last=%0b",
                             $time, m_tdata, m_tuser, m_tlast);
                end
                else
                begin
                    due_row = transformed_rows_due.pop_front();
                    for (int j = 0; j < witt_pkg::NUM_COLS; j++)
                    begin
                        got_coef = m_tdata[j*CW +: CW];
                        if (got_coef !== due_row.coef[j])
                        begin
                            errors++;
                            $display("%0t: row %0d coef_%0d: expected %0d, actual %0d",
                                     $time, due_row.row, j, $signed(due_row.coef[j]),
                                     $signed(got_coef));
                        end
                    end
                    if (m_tuser !== due_row.row)
                    begin
                        errors++;
                        $display("%0t: out_row: expected %0d, actual %0d",
                                 $time, due_row.row, m_tuser);
                    end
                    if (m_tlast !== due_row.last)
                    begin
                        errors++;
                        $display("%0t: row %0d tile_done: expected %0b, actual %0b",
                                 $time, due_row.row, due_row.last, m_tlast);
                    end
                    rows_checked++;
                    if (rows_checked % 64 == 0)
                        recv_stall_pct = pick_pct();
                end
            end
            if (recv_stall != 0)
            begin
                recv_stall <= recv_stall - 1;
                m_tready   <= 1'b0;
            end
            else if (!calm_tail() && $urandom_range(99) < recv_stall_pct)
            begin
                recv_stall <= $urandom_range(6, 0);
                m_tready   <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        // directed tiles: zero, rails, checkerboards, coefficient peaks
        queue_tile(PAT_ZERO, 1'b0, 1'b0);
        queue_tile(PAT_ALL_MAX, 1'b0, 1'b0);
        queue_tile(PAT_ALL_MIN, 1'b0, 1'b0);
        queue_tile(PAT_CHECKER, 1'b1, 1'b0);
        queue_tile(PAT_CHECKER_INV, 1'b0, 1'b0);
        queue_tile(PAT_COEF_PEAK, 1'b0, 1'b0);
        for (int t = 0; t < RANDOM_TILES; t++)
            queue_tile(PAT_RANDOM, $urandom_range(19) == 0, $urandom_range(4) == 0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (tile_rows_queued.size() != 0 || s_tvalid)
            @(posedge clk);
        while (transformed_rows_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d tile rows (%0d full tiles), checked %0d transformed rows.",
                 words_in, tiles_done, rows_checked);
        $display("Sender held off for a full drain %0d times; idle bursts on both sides.",
                 drains);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timed out with %0d rows still queued and %0d results due.",
                 tile_rows_queued.size(), transformed_rows_due.size());
        $display("testbench: errors");
        $finish;
    end

endmodule
